[design/polyphase_fir_interpolator_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the polyphase FIR interpolator unit
// Clocked property wrappers for the checker file.
// ----------------------------------------------------------------------------
`ifndef POLYPHASE_FIR_INTERPOLATOR_UNIT_ASSERT_SVH
`define POLYPHASE_FIR_INTERPOLATOR_UNIT_ASSERT_SVH

// Property checked at every rising edge outside reset.
`define PFI_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define PFI_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/pfi_pkg.sv]
// ----------------------------------------------------------------------------
// pfi_pkg
// Shared constants, item and result types of the polyphase FIR interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfi_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int MAX_FACTOR  = 8;
  localparam int MAX_TAPS    = 8;
  localparam int COEF_DEPTH  = MAX_FACTOR * MAX_TAPS;
  localparam int COEF_AW     = 6;
  localparam int CFG_W       = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int PHASE_W     = $clog2(MAX_FACTOR);
  localparam int TAP_W       = $clog2(MAX_TAPS);
  localparam int QUEUE_DEPTH = 4;

  localparam int S_FIELDS_W  = SAMPLE_W + COEF_AW + SAMPLE_W;
  localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_TDATA_W   = SAMPLE_W;
  localparam int M_TUSER_W   = PHASE_W;

  localparam logic [CFG_W-1:0] FACTOR_RESET = CFG_W'(2);
  localparam logic [CFG_W-1:0] TAPS_RESET   = CFG_W'(8);

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_COEF   = 1'b1
  } pfi_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FACTOR = 1'b0,
    CFG_TAPS   = 1'b1
  } pfi_cfg_idx_t;

  typedef struct packed {
    pfi_kind_t                   kind;
    logic signed [SAMPLE_W-1:0]  sample;
    logic [COEF_AW-1:0]          coef_index;
    logic signed [SAMPLE_W-1:0]  coef_value;
  } pfi_item_t;

  typedef struct packed {
    logic                        valid;
    logic signed [SAMPLE_W-1:0]  out_sample;
    logic [PHASE_W-1:0]          phase;
    logic                        last_of_run;
  } pfi_result_t;

endpackage

`default_nettype wire

[design/polyphase_fir_interpolator_unit.sv]
// ----------------------------------------------------------------------------
// polyphase_fir_interpolator_unit
// Polyphase FIR interpolator: each sample item gives one output item per
// phase; coefficient write items load the coefficient RAM in stream order.
//
//   channel  dir  handshake             payload
//   s_*      in   s_tvalid / s_tready   tdata: sample, coef_index, coef_value
//                                       tuser: cmd
//   m_*      out  m_tvalid / m_tready   tdata: out_sample  tuser: phase
//                                       tlast: last_of_run
//   cfg_*    in   cfg_we                cfg_index, cfg_wdata
//
// A sample item holds the engine until all factor * taps_per_phase taps
// issue, one multiply-accumulate and one coefficient RAM read a cycle
// unless the output stalls; each result then passes s1 to s4 and output
// registers. Reset clears the delay line, queue and pipeline and sets
// factor to 2 and taps_per_phase to 8; the coefficient RAM is not cleared.
// Low m_tready on waiting output freezes the engine; the 4-entry queue fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module polyphase_fir_interpolator_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // [15:0] sample, [21:16] coef_index, [37:22] coef_value, [39:38] zero
  input  wire logic [pfi_pkg::S_TDATA_W-1:0]     s_tdata,
  // [0] cmd
  input  wire logic                              s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [15:0] out_sample
  output logic [pfi_pkg::M_TDATA_W-1:0]          m_tdata,
  // [2:0] phase
  output logic [pfi_pkg::M_TUSER_W-1:0]          m_tuser,
  output logic                                   m_tlast,
  input  wire logic                              cfg_we,
  input  wire logic [pfi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pfi_pkg::CFG_W-1:0]         cfg_wdata
);

  import pfi_pkg::*;

  logic [CFG_W-1:0] factor;
  logic [CFG_W-1:0] taps_per_phase;
  logic             q_full;
  logic             push;
  pfi_item_t        push_item;
  logic             q_valid;
  logic             q_pop;
  pfi_item_t        q_item;
  pfi_result_t      res;

  always_ff @(posedge clk) begin
    if (rst) begin
      factor         <= FACTOR_RESET;
      taps_per_phase <= TAPS_RESET;
    end else if (cfg_we) begin
      unique case (pfi_cfg_idx_t'(cfg_index))
        CFG_FACTOR: factor         <= cfg_wdata;
        CFG_TAPS:   taps_per_phase <= cfg_wdata;
        default:    factor         <= factor;
      endcase
    end
  end

  pfi_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  pfi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_item)
  );

  pfi_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .factor         (factor),
    .taps_per_phase (taps_per_phase),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .res            (res),
    .res_ready      (m_tready)
  );

  assign m_tvalid = res.valid;
  assign m_tdata  = res.out_sample;
  assign m_tuser  = res.phase;
  assign m_tlast  = res.last_of_run;

endmodule

`default_nettype wire

[design/pfi_ram.sv]
// ----------------------------------------------------------------------------
// pfi_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/pfi_front.sv]
// ----------------------------------------------------------------------------
// pfi_front
// Input side: unpack stream items, classify sample versus coefficient write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfi_front (
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [pfi_pkg::S_TDATA_W-1:0]   s_tdata,
  input  wire logic                            s_tuser,
  input  wire logic                            q_full,
  output logic                                 push,
  output pfi_pkg::pfi_item_t                   push_item
);

  import pfi_pkg::*;

  localparam int IDX_LO = SAMPLE_W;
  localparam int VAL_LO = SAMPLE_W + COEF_AW;

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    push_item.kind       = s_tuser ? KIND_COEF : KIND_SAMPLE;
    push_item.sample     = $signed(s_tdata[SAMPLE_W-1:0]);
    push_item.coef_index = s_tdata[IDX_LO +: COEF_AW];
    push_item.coef_value = $signed(s_tdata[VAL_LO +: SAMPLE_W]);
  end

endmodule

`default_nettype wire

[design/pfi_queue.sv]
// ----------------------------------------------------------------------------
// pfi_queue
// Short item queue between the input side and the filter engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfi_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  pfi_pkg::pfi_item_t push_item,
  output logic               full,
  input  wire logic          pop,
  output logic               pop_valid,
  output pfi_pkg::pfi_item_t pop_item
);

  import pfi_pkg::*;

  localparam int QA_W = $clog2(QUEUE_DEPTH);

  pfi_item_t       mem [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_ptr;
  logic [QA_W-1:0] rd_ptr;
  logic [QA_W:0]   count;

  assign full      = (count == (QA_W + 1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QA_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QA_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (QA_W + 1)'(1);
        2'b01:   count <= count - (QA_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/pfi_engine.sv]
// ----------------------------------------------------------------------------
// pfi_engine
// Filter engine: coefficient RAM, delay line, one MAC stepped over phases and
// taps, scaling, rounding and saturation into a held output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfi_engine (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [pfi_pkg::CFG_W-1:0]  factor,
  input  wire logic [pfi_pkg::CFG_W-1:0]  taps_per_phase,
  input  wire logic                       q_valid,
  input  pfi_pkg::pfi_item_t              q_item,
  output logic                            q_pop,
  output pfi_pkg::pfi_result_t            res,
  input  wire logic                       res_ready
);

  import pfi_pkg::*;

  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int ACC_W    = PROD_W + TAP_W;
  localparam int SCALED_W = ACC_W + CFG_W + 1;

  localparam logic signed [SCALED_W-1:0] RND_BIAS =
    {{(SCALED_W - SAMPLE_W + 1){1'b0}}, 1'b1, {(SAMPLE_W - 2){1'b0}}};
  localparam logic signed [SCALED_W-1:0] SAT_MAX =
    {{(SCALED_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
  localparam logic signed [SCALED_W-1:0] SAT_MIN =
    {{(SCALED_W - SAMPLE_W + 1){1'b1}}, {(SAMPLE_W - 1){1'b0}}};

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    if (v == '0) begin
      return CFG_W'(1);
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  state_t                      state;
  logic signed [SAMPLE_W-1:0]  delay [MAX_TAPS];
  logic [CFG_W-1:0]            f_q;
  logic [CFG_W-1:0]            tpp_q;
  logic [PHASE_W-1:0]          p_q;
  logic [TAP_W-1:0]            t_q;
  logic [COEF_AW-1:0]          addr_q;

  logic                        s1_valid;
  logic [TAP_W-1:0]            s1_tap;
  logic                        s1_first;
  logic                        s1_last;
  logic [PHASE_W-1:0]          s1_phase;
  logic                        s1_runend;
  logic [CFG_W-1:0]            s1_f;

  logic                        s2_valid;
  logic signed [PROD_W-1:0]    s2_prod;
  logic                        s2_first;
  logic                        s2_last;
  logic [PHASE_W-1:0]          s2_phase;
  logic                        s2_runend;
  logic [CFG_W-1:0]            s2_f;

  logic                        s3_valid;
  logic signed [ACC_W-1:0]     s3_acc;
  logic [PHASE_W-1:0]          s3_phase;
  logic                        s3_runend;
  logic [CFG_W-1:0]            s3_f;

  logic                        s4_valid;
  logic signed [SCALED_W-1:0]  s4_scaled;
  logic [PHASE_W-1:0]          s4_phase;
  logic                        s4_runend;

  logic                        adv;
  logic                        issue;
  logic                        t_last;
  logic                        p_last;
  logic [SAMPLE_W-1:0]         ram_rdata;
  logic signed [SCALED_W-1:0]  rnd;
  logic signed [SCALED_W-1:0]  shifted;
  logic signed [SAMPLE_W-1:0]  sat;

  assign adv    = !res.valid || res_ready;
  assign issue  = (state == ST_RUN);
  assign q_pop  = adv && (state == ST_IDLE) && q_valid;
  assign t_last = (CFG_W'(t_q) == tpp_q - CFG_W'(1));
  assign p_last = (CFG_W'(p_q) == f_q - CFG_W'(1));

  pfi_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (COEF_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (q_pop && (q_item.kind == KIND_COEF)),
    .waddr (q_item.coef_index),
    .wdata (q_item.coef_value),
    .re    (adv && issue),
    .raddr (addr_q),
    .rdata (ram_rdata)
  );

  always_comb begin
    rnd     = s4_scaled + RND_BIAS;
    shifted = rnd >>> (SAMPLE_W - 1);
    if (shifted > SAT_MAX) begin
      sat = SAT_MAX[SAMPLE_W-1:0];
    end else if (shifted < SAT_MIN) begin
      sat = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      sat = shifted[SAMPLE_W-1:0];
    end
  end

  // Sequencer, delay line, payload pipeline and stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      f_q       <= FACTOR_RESET;
      tpp_q     <= TAPS_RESET;
      p_q       <= '0;
      t_q       <= '0;
      addr_q    <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      res.valid <= 1'b0;
      for (int i = 0; i < MAX_TAPS; i++) begin
        delay[i] <= '0;
      end
    end else if (adv) begin
      s1_tap    <= t_q;
      s1_first  <= (t_q == '0);
      s1_last   <= t_last;
      s1_phase  <= p_q;
      s1_runend <= p_last;
      s1_f      <= f_q;

      s2_prod   <= $signed(ram_rdata) * delay[s1_tap];
      s2_first  <= s1_first;
      s2_last   <= s1_last;
      s2_phase  <= s1_phase;
      s2_runend <= s1_runend;
      s2_f      <= s1_f;

      if (s2_valid) begin
        s3_acc <= s2_first ? ACC_W'(s2_prod) : s3_acc + ACC_W'(s2_prod);
      end
      s3_phase  <= s2_phase;
      s3_runend <= s2_runend;
      s3_f      <= s2_f;

      s4_scaled <= s3_acc * $signed({1'b0, s3_f});
      s4_phase  <= s3_phase;
      s4_runend <= s3_runend;

      res.out_sample  <= sat;
      res.phase       <= s4_phase;
      res.last_of_run <= s4_runend;

      s1_valid  <= issue;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid && s2_last;
      s4_valid  <= s3_valid;
      res.valid <= s4_valid;
      unique case (state)
        ST_IDLE: begin
          if (q_pop && (q_item.kind == KIND_SAMPLE)) begin
            for (int i = MAX_TAPS - 1; i > 0; i--) begin
              delay[i] <= delay[i-1];
            end
            delay[0] <= q_item.sample;
            f_q      <= clamp_cfg(factor, CFG_W'(MAX_FACTOR));
            tpp_q    <= clamp_cfg(taps_per_phase, CFG_W'(MAX_TAPS));
            p_q      <= '0;
            t_q      <= '0;
            addr_q   <= '0;
            state    <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (t_last) begin
            t_q <= '0;
            if (p_last) begin
              state <= ST_IDLE;
            end else begin
              p_q    <= p_q + PHASE_W'(1);
              addr_q <= COEF_AW'(p_q) + COEF_AW'(1);
            end
          end else begin
            t_q    <= t_q + TAP_W'(1);
            addr_q <= addr_q + COEF_AW'(f_q);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/pfi_checker.sv]
// ----------------------------------------------------------------------------
// pfi_checker
// Port-level checks of the interpolator output stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "polyphase_fir_interpolator_unit_assert.svh"

module pfi_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tvalid,
  input wire logic                              s_tready,
  input wire logic [pfi_pkg::S_TDATA_W-1:0]     s_tdata,
  input wire logic                              s_tuser,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [pfi_pkg::M_TDATA_W-1:0]     m_tdata,
  input wire logic [pfi_pkg::M_TUSER_W-1:0]     m_tuser,
  input wire logic                              m_tlast,
  input wire logic                              cfg_we,
  input wire logic [pfi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input wire logic [pfi_pkg::CFG_W-1:0]         cfg_wdata
);

  import pfi_pkg::*;

  localparam logic [M_TUSER_W-1:0] TOP_PHASE = M_TUSER_W'(MAX_FACTOR - 1);

  logic unused_inputs;
  assign unused_inputs = ^{s_tvalid, s_tready, s_tdata, s_tuser,
                           cfg_we, cfg_index, cfg_wdata};

  `PFI_ASSERT_ALWAYS(a_reset_clears_out, clk,
    rst |=> !m_tvalid, "output valid after reset")

  `PFI_ASSERT(a_stall_holds, clk, rst,
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
    "stalled output item changed")

  `PFI_ASSERT(a_top_phase_is_last, clk, rst,
    m_tvalid && (m_tuser == TOP_PHASE) |-> m_tlast, "highest phase not marked last")

  `PFI_ASSERT(a_phase_steps, clk, rst,
    (m_tvalid && m_tready && !m_tlast) ##1 m_tvalid |-> m_tuser == $past(m_tuser) + M_TUSER_W'(1),
    "phase of run does not advance by one")

endmodule

bind polyphase_fir_interpolator_unit pfi_checker u_pfi_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .s_tdata   (s_tdata),
  .s_tuser   (s_tuser),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .m_tlast   (m_tlast),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_wdata (cfg_wdata)
);

`default_nettype wire
